@@ rtl/pcm_pkg.sv @@
// Shared constants, register codes and palette functions for the pseudo-color mapper.
package pcm_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COLOR_COUNT   = 500;
    localparam int IDX_W         = 9;
    localparam int COMP_W        = 8;
    localparam int RGB_W         = 3 * COMP_W;
    localparam int CFG_IDX_W     = 2;
    localparam int MODE_W        = 3;

    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(COLOR_COUNT - 1);
    localparam logic [IDX_W-1:0] SEG_1    = IDX_W'(100);
    localparam logic [IDX_W-1:0] SEG_2    = IDX_W'(200);
    localparam logic [IDX_W-1:0] SEG_3    = IDX_W'(300);
    localparam logic [IDX_W-1:0] SEG_4    = IDX_W'(400);
    localparam logic [IDX_W-1:0] SEG_5    = IDX_W'(COLOR_COUNT);
    localparam logic [IDX_W-1:0] HALF_1   = IDX_W'(125);
    localparam logic [IDX_W-1:0] HALF_2   = IDX_W'(250);
    localparam logic [9:0]       BWR_TOP  = 10'd506;
    localparam logic [COMP_W-1:0] COMP_MAX = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = 2'd2;

    // palette modes
    localparam logic [MODE_W-1:0] MODE_RED     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GREEN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLUE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BWR     = 3'd4;

    localparam logic [DATA_W-1:0] MIN_RESET   = 32'd0;
    localparam logic [DATA_W-1:0] SCALE_RESET = 32'd65536;

    // floor(z/25) via reciprocal; exact for z < 43690
    function automatic logic [COMP_W-1:0] div25(input logic [15:0] z);
        logic [28:0] p;
        p = 29'(z) * 29'd5243;
        return p[24:17];
    endfunction

    // floor(d*255/100) for d <= 100
    function automatic logic [COMP_W-1:0] seg_ramp(input logic [IDX_W-1:0] d);
        logic [15:0] t;
        t = 16'(d) * 16'd255;
        return div25(t >> 2);
    endfunction

    // {red, green, blue} of palette entry j
    function automatic logic [RGB_W-1:0] palette_color(input logic [IDX_W-1:0] j,
                                                       input logic [MODE_W-1:0] mode);
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        logic [COMP_W-1:0] ramp;
        logic [15:0]       m51;
        logic [15:0]       j5;
        logic [9:0]        tail;
        r    = '0;
        g    = '0;
        b    = '0;
        m51  = 16'(j) * 16'd51;
        ramp = div25(m51 >> 2);           // j*255/500 = (j*51/4)/25
        j5   = 16'(j) * 16'd5;
        tail = BWR_TOP - 10'(j);
        unique case (mode)
            MODE_RED:   r = ramp;
            MODE_GREEN: g = ramp;
            MODE_BLUE:  b = ramp;
            MODE_RAINBOW:
            begin
                if (j < SEG_1) begin
                    b = j5[8:1];
                end else if (j < SEG_2) begin
                    g = seg_ramp(j - SEG_1);
                    b = COMP_MAX;
                end else if (j < SEG_3) begin
                    g = COMP_MAX;
                    b = seg_ramp(SEG_3 - j);
                end else if (j < SEG_4) begin
                    r = seg_ramp(j - SEG_3);
                    g = COMP_MAX;
                end else begin
                    r = COMP_MAX;
                    g = seg_ramp(SEG_5 - j);
                end
            end
            MODE_BWR:
            begin
                if (j < HALF_1) begin
                    b = {j[6:0], 1'b0};
                end else if (j <= HALF_2) begin
                    r = div25(16'(j - HALF_1) * 16'd51);
                    g = r;
                    b = COMP_MAX;
                end else begin
                    r = COMP_MAX;
                    g = tail[COMP_W-1:0];
                    b = tail[COMP_W-1:0];
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return {r, g, b};
    endfunction

endpackage

@@ rtl/pseudo_color_mapper.sv @@
// Top level of the pseudo-color mapper: sample to palette index to RGB via a colormap RAM.
//
// Usage
//   Input requests: data_value is taken at a rising edge with start high and
//   busy low. While busy is low a new request may follow every clock, so the
//   rate is one sample per cycle, set by the single-read-port RAM lookup.
//   Results: done pulses for one cycle with color_index, red/green/blue and
//   the inverted color, after the registered stages (subtract, 32x32
//   multiply, clamp plus RAM read). The receiver cannot stall, so nothing
//   is buffered beyond the pipeline itself.
//   Configuration: cfg_we/cfg_index/cfg_data write min_value (0), scale (1)
//   and palette_mode (2); write only while no request is in flight (unchecked).
//   Colormap RAM: holds the 500 RGB entries of the current palette. After
//   reset, and after every palette_mode write, a fill pass writes one entry
//   per cycle, in order; busy is high during that pass and no request
//   is taken. Reset clears the pipeline valids and loads register defaults
//   (min 0, scale 1.0, rainbow palette).
module pseudo_color_mapper #(
    parameter int FRAC_BITS = pcm_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [pcm_pkg::DATA_W-1:0]   data_value,
    input  logic                                cfg_we,
    input  logic [pcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcm_pkg::DATA_W-1:0]          cfg_data,
    output logic                                done,
    output logic [pcm_pkg::IDX_W-1:0]           color_index,
    output logic [pcm_pkg::COMP_W-1:0]          red,
    output logic [pcm_pkg::COMP_W-1:0]          green,
    output logic [pcm_pkg::COMP_W-1:0]          blue,
    output logic [pcm_pkg::COMP_W-1:0]          inv_red,
    output logic [pcm_pkg::COMP_W-1:0]          inv_green,
    output logic [pcm_pkg::COMP_W-1:0]          inv_blue
);

    localparam int DW    = pcm_pkg::DATA_W;
    localparam int PW    = 2 * DW;
    localparam int SHIFT = 2 * FRAC_BITS;
    localparam int HI_W  = PW - SHIFT;

    // configuration
    logic signed [DW-1:0]            min_value_reg;
    logic [DW-1:0]                   scale_reg;
    logic [pcm_pkg::MODE_W-1:0]      mode_reg;

    // colormap fill pass
    logic                            fill_active_reg, fill_active_next;
    logic [pcm_pkg::IDX_W-1:0]       fill_cnt_reg, fill_cnt_next;
    logic                            mode_write;

    // pipeline
    logic                            v1_reg, v2_reg, v3_reg;
    logic signed [DW:0]              diff_reg, diff_next;
    logic [PW-1:0]                   prod_reg, prod_next;
    logic [pcm_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [HI_W-1:0]                 prod_hi;
    logic                            diff_pos;
    logic                            accept;

    logic [pcm_pkg::RGB_W-1:0]       ram_wdata;
    logic [pcm_pkg::RGB_W-1:0]       ram_rdata;

    assign busy       = fill_active_reg;
    assign accept     = start && !fill_active_reg;
    assign mode_write = cfg_we && (cfg_index == pcm_pkg::REG_PALETTE_MODE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg <= pcm_pkg::MIN_RESET;
            scale_reg     <= pcm_pkg::SCALE_RESET;
            mode_reg      <= pcm_pkg::MODE_RAINBOW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcm_pkg::REG_MIN_VALUE:    min_value_reg <= cfg_data;
                pcm_pkg::REG_SCALE:        scale_reg     <= cfg_data;
                pcm_pkg::REG_PALETTE_MODE: mode_reg      <= cfg_data[pcm_pkg::MODE_W-1:0];
                default:                   ;
            endcase
        end
    end

    // fill pass: restarts on every palette change
    always_comb
    begin
        fill_active_next = fill_active_reg;
        fill_cnt_next    = fill_cnt_reg;
        if (mode_write)
        begin
            fill_active_next = 1'b1;
            fill_cnt_next    = '0;
        end
        else if (fill_active_reg)
        begin
            fill_cnt_next = fill_cnt_reg + 1'b1;
            if (fill_cnt_reg == pcm_pkg::IDX_MAX)
            begin
                fill_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b1;
            fill_cnt_reg    <= '0;
        end
        else
        begin
            fill_active_reg <= fill_active_next;
            fill_cnt_reg    <= fill_cnt_next;
        end
    end

    assign ram_wdata = pcm_pkg::palette_color(fill_cnt_reg, mode_reg);

    // stage 1: offset, stage 2: scale, stage 3: clamp and colormap read
    assign diff_next = (DW + 1)'(data_value) - (DW + 1)'(min_value_reg);
    assign diff_pos  = !diff_reg[DW] && (diff_reg[DW-1:0] != '0);
    assign prod_next = diff_pos ? (PW'(diff_reg[DW-1:0]) * PW'(scale_reg)) : '0;
    assign prod_hi   = prod_reg[PW-1:SHIFT];
    assign idx_next  = (prod_hi >= HI_W'(pcm_pkg::IDX_MAX)) ? pcm_pkg::IDX_MAX
                                                            : prod_hi[pcm_pkg::IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    pcm_ram #(
        .WIDTH (pcm_pkg::RGB_W),
        .DEPTH (pcm_pkg::COLOR_COUNT)
    ) u_cmap (
        .clk   (clk),
        .we    (fill_active_reg),
        .waddr (fill_cnt_reg),
        .wdata (ram_wdata),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    // results; RAM data and index land on the same edge
    assign done        = v3_reg;
    assign color_index = idx_reg;
    assign red         = ram_rdata[3*pcm_pkg::COMP_W-1:2*pcm_pkg::COMP_W];
    assign green       = ram_rdata[2*pcm_pkg::COMP_W-1:pcm_pkg::COMP_W];
    assign blue        = ram_rdata[pcm_pkg::COMP_W-1:0];
    assign inv_red     = pcm_pkg::COMP_MAX - red;
    assign inv_green   = pcm_pkg::COMP_MAX - green;
    assign inv_blue    = pcm_pkg::COMP_MAX - blue;

    // checks
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_active_reg |-> (fill_cnt_reg <= pcm_pkg::IDX_MAX))
        else $error("fill counter beyond colormap");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (color_index <= pcm_pkg::IDX_MAX))
        else $error("palette index beyond colormap");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("request without result three cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without matching request");

endmodule

@@ rtl/pcm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module pcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 500
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ tb/pseudo_color_mapper_tb.sv @@
// Self-checking testbench for the pseudo-color mapper: index, color and inverse per sample.
module pseudo_color_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcm_pkg::*;

    // Palette segment lengths, used by the color predictor
    localparam int RAMP_SEG  = 100;     // rainbow segment
    localparam int BWR_HALF  = 125;     // blue-white-red first knee
    localparam int IDX_TOP   = COLOR_COUNT - 1;
    localparam int SHIFT     = 2 * FRAC_BITS_DEF;
    localparam logic [DATA_W-1:0] SCALE_ONE = 32'd1 << FRAC_BITS_DEF;

    // Modes 5..7 have no palette and map to black
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LAST  = 3'd7;

    localparam int NUM_PHASES = 13;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        logic [COMP_W-1:0] ir;
        logic [COMP_W-1:0] ig;
        logic [COMP_W-1:0] ib;
    } color_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [DATA_W-1:0]   data_value = '0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_MIN_VALUE;
    logic [DATA_W-1:0]          cfg_data = '0;
    logic                       done;
    logic [IDX_W-1:0]           color_index;
    logic [COMP_W-1:0]          red;
    logic [COMP_W-1:0]          green;
    logic [COMP_W-1:0]          blue;
    logic [COMP_W-1:0]          inv_red;
    logic [COMP_W-1:0]          inv_green;
    logic [COMP_W-1:0]          inv_blue;

    // Predictor's copy of the register file (reset values)
    logic signed [DATA_W-1:0]   cur_min   = MIN_RESET;
    logic [DATA_W-1:0]          cur_scale = SCALE_RESET;
    logic [MODE_W-1:0]          cur_mode  = MODE_RAINBOW;

    logic [DATA_W-1:0]          pending_samples[$];   // requests not yet issued
    color_result_t              expected_colors[$];   // predicted results in order
    int                         gap_left = 0;
    bit                         no_gaps = 1'b0;       // set for the closing stretch
    int                         mismatches = 0;

    pseudo_color_mapper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .data_value  (data_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .color_index (color_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .inv_red     (inv_red),
        .inv_green   (inv_green),
        .inv_blue    (inv_blue)
    );

    always #5 clk = ~clk;

    // Palette index and color for one sample under the current registers.
    // The index is (sample - min) * scale with 2*FRAC fraction bits, truncated,
    // zero when the difference is not positive, and saturated at the top entry.
    function automatic color_result_t map_sample(input logic signed [DATA_W-1:0] value);
        logic signed [DATA_W:0] diff;
        logic [63:0]            prod;
        logic [63:0]            pos;
        int                     j;
        int                     r;
        int                     g;
        int                     b;
        color_result_t          res;
        diff = $signed({value[DATA_W-1], value}) - $signed({cur_min[DATA_W-1], cur_min});
        if (diff <= 0) begin
            j = 0;
        end else begin
            prod = 64'(diff[DATA_W-1:0]) * 64'(cur_scale);
            pos  = prod >> SHIFT;
            j    = (pos >= 64'(IDX_TOP)) ? IDX_TOP : int'(pos);
        end
        r = 0;
        g = 0;
        b = 0;
        case (cur_mode)
            MODE_RED:   r = j * 255 / COLOR_COUNT;
            MODE_GREEN: g = j * 255 / COLOR_COUNT;
            MODE_BLUE:  b = j * 255 / COLOR_COUNT;
            MODE_RAINBOW:
            begin
                // blue rise, cyan, green, yellow, red: five segments of 100
                if (j < RAMP_SEG) begin
                    b = j * 5 / 2;
                end else if (j < 2 * RAMP_SEG) begin
                    g = (j - RAMP_SEG) * 255 / RAMP_SEG;
                    b = 255;
                end else if (j < 3 * RAMP_SEG) begin
                    g = 255;
                    b = (3 * RAMP_SEG - j) * 255 / RAMP_SEG;
                end else if (j < 4 * RAMP_SEG) begin
                    r = (j - 3 * RAMP_SEG) * 255 / RAMP_SEG;
                    g = 255;
                end else begin
                    r = 255;
                    g = (5 * RAMP_SEG - j) * 255 / RAMP_SEG;
                end
            end
            MODE_BWR:
            begin
                // blue up to white at the midpoint, then fade toward red
                if (j < BWR_HALF) begin
                    b = 2 * j;
                end else if (j <= 2 * BWR_HALF) begin
                    r = (j - BWR_HALF) * 255 / BWR_HALF;
                    g = r;
                    b = 255;
                end else begin
                    r = 255;
                    g = 506 - j;
                    b = g;
                end
            end
            default:
            begin
                r = 0;  // unused modes give black
            end
        endcase
        res.idx = IDX_W'(j);
        res.r   = COMP_W'(r);
        res.g   = COMP_W'(g);
        res.b   = COMP_W'(b);
        res.ir  = COMP_W'(255 - r);
        res.ig  = COMP_W'(255 - g);
        res.ib  = COMP_W'(255 - b);
        return res;
    endfunction

    // Mostly samples aimed at a chosen palette entry (sometimes exactly on its
    // lower edge, a few past the top), the rest raw 32-bit noise.
    function automatic logic [DATA_W-1:0] pick_sample(input logic [DATA_W-1:0] lo,
                                                      input logic [DATA_W-1:0] sc);
        logic [63:0] span;
        logic [63:0] offs;
        if (sc == 0 || $urandom_range(9) < 2)
            return $urandom();
        span = 64'($urandom_range(0, COLOR_COUNT + 20)) << SHIFT;
        if ($urandom_range(3) == 0)
            span = span + 64'(sc) - 64'd1;  // smallest offset reaching the entry
        else
            span = span + 64'($urandom());
        offs = span / 64'(sc);
        if (offs > 64'hFFFF_FFFF)
            offs = 64'hFFFF_FFFF;
        return lo + offs[DATA_W-1:0];
    endfunction

    // Register write; also updates the predictor's copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_MIN_VALUE:    cur_min   = val;
            REG_SCALE:        cur_scale = val;
            REG_PALETTE_MODE: cur_mode  = val[MODE_W-1:0];
            default:          cur_min   = cur_min;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Block until every queued request has been issued and answered.
    // Checked on the falling edge so the rising-edge updates have settled.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || start || expected_colors.size() != 0);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // Request driver: issues queued samples, with random idle bursts in between.
    // Prediction happens at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start      <= 1'b0;
            data_value <= '0;
            gap_left   <= 0;
        end else begin
            if (start && !busy)
                expected_colors.push_back(map_sample(data_value));
            if (start && busy) begin
                start <= 1'b1;              // hold the request until taken
            end else if (gap_left > 0) begin
                start      <= 1'b0;
                data_value <= $urandom();   // junk while idle must be ignored
                gap_left   <= gap_left - 1;
            end else if (pending_samples.size() != 0 && !no_gaps && $urandom_range(15) == 0) begin
                start      <= 1'b0;
                data_value <= $urandom();
                gap_left   <= $urandom_range(16);
            end else if (pending_samples.size() != 0) begin
                start      <= 1'b1;
                data_value <= pending_samples.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: each done pulse is matched against the oldest prediction
    always @(posedge clk)
    begin
        color_result_t want;
        if (rst_n && done) begin
            if (expected_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request outstanding (index %0d)",
                             $realtime, color_index);
            end else begin
                want = expected_colors.pop_front();
                check_field("color_index", color_index, want.idx);
                check_field("red",         red,         want.r);
                check_field("green",       green,       want.g);
                check_field("blue",        blue,        want.b);
                check_field("inv_red",     inv_red,     want.ir);
                check_field("inv_green",   inv_green,   want.ig);
                check_field("inv_blue",    inv_blue,    want.ib);
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int                 entries[15];
        logic [DATA_W-1:0]  lo;
        logic [DATA_W-1:0]  sc;
        logic [MODE_W-1:0]  mode;
        int                 count;
        entries = '{1, 99, 100, 124, 125, 199, 200, 250, 251, 299, 300, 399, 400, 499, 500};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset registers (min 0, scale 1.0, rainbow): with unit
        // scale the integer part of the sample is the palette index, so each
        // segment edge and the saturation point can be hit exactly.
        @(negedge clk);
        pending_samples.push_back(32'h0000_0000);
        pending_samples.push_back(32'hFFFF_FFFF);   // below the minimum
        pending_samples.push_back(32'h0000_FFFF);   // fraction only
        foreach (entries[k])
            pending_samples.push_back(DATA_W'(entries[k]) << FRAC_BITS_DEF);
        pending_samples.push_back(32'h7FFF_FFFF);   // saturates
        pending_samples.push_back(32'h8000_0000);
        wait_idle();

        // Directed: zero scale and a palette-less mode, lowest minimum
        write_reg(REG_MIN_VALUE, 32'h8000_0000);
        write_reg(REG_SCALE, '0);
        write_reg(REG_PALETTE_MODE, DATA_W'(MODE_LAST));
        @(negedge clk);
        pending_samples.push_back(32'h7FFF_FFFF);
        pending_samples.push_back(32'h8000_0000);
        pending_samples.push_back(32'h0000_0000);
        wait_idle();

        // Random phases, one register setting each; modes cycle through all eight
        for (int p = 0; p < NUM_PHASES; p++) begin
            mode  = MODE_W'(p % 8);
            count = 120;
            case (p)
                0:
                begin
                    lo = 32'h8000_0000;
                    sc = SCALE_ONE;
                end
                1:
                begin
                    lo    = 32'h7FFF_FFFF;     // nothing above the minimum
                    sc    = 32'hFFFF_FFFF;
                    count = 40;
                end
                2:
                begin
                    lo = $urandom();
                    sc = 32'hFFFF_FFFF;
                end
                3:
                begin
                    lo = $urandom();
                    sc = 32'd1;
                end
                default:
                begin
                    if ($urandom_range(1) == 0)
                        lo = $urandom();
                    else
                        lo = DATA_W'($urandom_range(0, 2000000)) - 32'd1000000;
                    case ($urandom_range(3))
                        0:       sc = SCALE_ONE;
                        1:       sc = SCALE_ONE << 4;
                        2:       sc = SCALE_ONE >> 4;
                        default: sc = $urandom();
                    endcase
                end
            endcase
            if (p == NUM_PHASES - 1) begin
                mode    = MODE_SPARE + MODE_W'($urandom_range(2));
                count   = 150;
                no_gaps = 1'b1;                // closing stretch runs back to back
            end
            write_reg(REG_MIN_VALUE, lo);
            write_reg(REG_SCALE, sc);
            write_reg(REG_PALETTE_MODE, DATA_W'(mode));
            @(negedge clk);
            repeat (count)
                pending_samples.push_back(pick_sample(lo, sc));
            wait_idle();
        end

        // Pipeline is three deep; give stray pulses a chance to show up
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (fill passes plus maximal gaps)
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
